[src/ldaa_pkg.sv]
package ldaa_pkg;

    localparam int FRAC         = 30;
    localparam int DIV_STEPS    = 31;
    localparam int SQRT_STEPS   = 31;
    localparam int CORDIC_STEPS = 30;
    // divide, square, radicand/cube, root, r*s, rotations, final sum
    localparam int G_LAT        = DIV_STEPS + 2 + SQRT_STEPS + 1 + CORDIC_STEPS + 1;
    localparam int Q_BITS       = 17;
    localparam int TOTAL_LAT    = 1 + G_LAT + 6 + Q_BITS + 1;

    localparam int NUM_CFG   = 7;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_STAR_RADIUS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIN_BAND0   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_QUAD_BAND0  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LIN_BAND1   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_QUAD_BAND1  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LIN_BAND2   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_QUAD_BAND2  = 3'd6;

    localparam logic [15:0] STAR_RADIUS_RESET = 16'd32768;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EQUAL    = 2'd1,
        ST_BEYOND   = 2'd2,
        ST_BAD_BAND = 2'd3
    } status_t;

    typedef struct packed {
        logic [15:0] inner_radius;
        logic [15:0] outer_radius;
        logic [1:0]  band;
    } in_word_t;

    typedef struct packed {
        logic signed [15:0] mean_intensity;
        logic [1:0]         status;
    } out_word_t;

    typedef struct packed {
        status_t            status;
        logic signed [17:0] c1;
        logic signed [17:0] c2;
        logic signed [15:0] b;
    } side_t;

    // arctangent of 2^-i in Q30; beyond the table it equals 2^-i
    function automatic logic signed [32:0] atan_q30(input int unsigned i);
        logic signed [32:0] v;
        case (i)
            0:       v = 33'sd843314857;
            1:       v = 33'sd497837829;
            2:       v = 33'sd263043837;
            3:       v = 33'sd133525159;
            4:       v = 33'sd67021687;
            5:       v = 33'sd33543516;
            6:       v = 33'sd16775851;
            7:       v = 33'sd8388437;
            8:       v = 33'sd4194283;
            9:       v = 33'sd2097149;
            10:      v = 33'sd1048576;
            default: v = 33'(64'd1 << (FRAC - i));
        endcase
        return v;
    endfunction

endpackage

[src/ldaa_gterm.sv]
// Per-radius term: r = radius/star in Q30, G(r) = r*sqrt(1-r^2) + asin(r), r^3.
module ldaa_gterm (
    input  logic               clk,
    input  logic               en,
    input  logic [15:0]        radius,
    input  logic [15:0]        star_radius,
    output logic [30:0]        r_norm,
    output logic signed [33:0] g_val,
    output logic [30:0]        cube
);

    // restoring divide, one quotient bit per stage
    logic [15:0] drem_reg [0:ldaa_pkg::DIV_STEPS-1];
    logic [30:0] dq_reg   [0:ldaa_pkg::DIV_STEPS-1];
    logic        dge0;

    assign dge0 = radius >= star_radius;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            drem_reg[0] <= dge0 ? radius - star_radius : radius;
            dq_reg[0]   <= {dge0, 30'd0};
        end
    end

    genvar j;
    for (j = 1; j < ldaa_pkg::DIV_STEPS; j++)
    begin : g_div
        logic [16:0] rem2;
        logic        ge;
        assign rem2 = {drem_reg[j-1], 1'b0};
        assign ge   = rem2 >= {1'b0, star_radius};
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                drem_reg[j] <= ge ? 16'(rem2 - {1'b0, star_radius}) : rem2[15:0];
                dq_reg[j]   <= dq_reg[j-1] | (ge ? (31'd1 << (30 - j)) : 31'd0);
            end
        end
    end

    // square, then radicand and cube
    logic [61:0] sq_reg;
    logic [30:0] ra_reg;
    logic [60:0] v_reg;
    logic [30:0] rb_reg;
    logic [30:0] cb_reg;
    logic [61:0] cprod;

    assign cprod = 62'(sq_reg[60:30]) * 62'(ra_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_reg <= 62'(dq_reg[ldaa_pkg::DIV_STEPS-1]) * 62'(dq_reg[ldaa_pkg::DIV_STEPS-1]);
            ra_reg <= dq_reg[ldaa_pkg::DIV_STEPS-1];
            v_reg  <= (61'd1 << 60) - sq_reg[60:0];
            rb_reg <= ra_reg;
            cb_reg <= cprod[60:30];
        end
    end

    // exact integer root, one result bit per stage
    logic [60:0] sv_reg   [0:ldaa_pkg::SQRT_STEPS-1];
    logic [62:0] sres_reg [0:ldaa_pkg::SQRT_STEPS-1];
    logic [30:0] spr_reg  [0:ldaa_pkg::SQRT_STEPS-1];
    logic [30:0] spc_reg  [0:ldaa_pkg::SQRT_STEPS-1];

    genvar k;
    for (k = 0; k < ldaa_pkg::SQRT_STEPS; k++)
    begin : g_sqrt
        localparam logic [62:0] BITV = 63'd1 << (2 * (ldaa_pkg::SQRT_STEPS - 1 - k));
        logic [62:0] pv;
        logic [62:0] pres;
        logic [62:0] trial;
        logic [30:0] pr;
        logic [30:0] pc;
        logic        take;
        if (k == 0)
        begin : g_first
            assign pv   = {2'b0, v_reg};
            assign pres = '0;
            assign pr   = rb_reg;
            assign pc   = cb_reg;
        end
        else
        begin : g_rest
            assign pv   = {2'b0, sv_reg[k-1]};
            assign pres = sres_reg[k-1];
            assign pr   = spr_reg[k-1];
            assign pc   = spc_reg[k-1];
        end
        assign trial = pres + BITV;
        assign take  = pv >= trial;
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sv_reg[k]   <= take ? 61'(pv - trial) : pv[60:0];
                sres_reg[k] <= take ? (pres >> 1) + BITV : pres >> 1;
                spr_reg[k]  <= pr;
                spc_reg[k]  <= pc;
            end
        end
    end

    // r*s and rotation seed, then vectoring rotations
    logic signed [33:0] cx_reg  [0:ldaa_pkg::CORDIC_STEPS];
    logic signed [33:0] cy_reg  [0:ldaa_pkg::CORDIC_STEPS];
    logic signed [32:0] cz_reg  [0:ldaa_pkg::CORDIC_STEPS];
    logic [30:0]        cr_reg  [0:ldaa_pkg::CORDIC_STEPS];
    logic [30:0]        cc_reg  [0:ldaa_pkg::CORDIC_STEPS];
    logic [30:0]        crs_reg [0:ldaa_pkg::CORDIC_STEPS];
    logic [30:0]        s_root;
    logic [61:0]        rsprod;

    assign s_root = sres_reg[ldaa_pkg::SQRT_STEPS-1][30:0];
    assign rsprod = 62'(spr_reg[ldaa_pkg::SQRT_STEPS-1]) * 62'(s_root);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cx_reg[0]  <= $signed({3'b0, s_root});
            cy_reg[0]  <= $signed({3'b0, spr_reg[ldaa_pkg::SQRT_STEPS-1]});
            cz_reg[0]  <= '0;
            cr_reg[0]  <= spr_reg[ldaa_pkg::SQRT_STEPS-1];
            cc_reg[0]  <= spc_reg[ldaa_pkg::SQRT_STEPS-1];
            crs_reg[0] <= rsprod[60:30];
        end
    end

    genvar i;
    for (i = 0; i < ldaa_pkg::CORDIC_STEPS; i++)
    begin : g_cordic
        localparam logic signed [32:0] ANG = ldaa_pkg::atan_q30(i);
        logic signed [33:0] xs;
        logic signed [33:0] ys;
        logic               pos;
        assign xs  = cx_reg[i] >>> i;
        assign ys  = cy_reg[i] >>> i;
        assign pos = cy_reg[i] > 34'sd0;
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                cx_reg[i+1]  <= pos ? cx_reg[i] + ys : cx_reg[i] - ys;
                cy_reg[i+1]  <= pos ? cy_reg[i] - xs : cy_reg[i] + xs;
                cz_reg[i+1]  <= pos ? cz_reg[i] + ANG : cz_reg[i] - ANG;
                cr_reg[i+1]  <= cr_reg[i];
                cc_reg[i+1]  <= cc_reg[i];
                crs_reg[i+1] <= crs_reg[i];
            end
        end
    end

    logic [30:0]        r_out_reg;
    logic signed [33:0] g_out_reg;
    logic [30:0]        c_out_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_out_reg <= cr_reg[ldaa_pkg::CORDIC_STEPS];
            c_out_reg <= cc_reg[ldaa_pkg::CORDIC_STEPS];
            g_out_reg <= $signed({3'b0, crs_reg[ldaa_pkg::CORDIC_STEPS]})
                         + 34'(cz_reg[ldaa_pkg::CORDIC_STEPS]);
        end
    end

    assign r_norm = r_out_reg;
    assign g_val  = g_out_reg;
    assign cube   = c_out_reg;

endmodule

[src/limb_darkened_annulus_average.sv]
// Words pass stage 0, the term pipelines, M1 to M6, the quotient stages, out_reg.
// Throughput: one word per cycle; the whole pipeline advances together and
// holds while the output register is full and out_ready is low.
// Reset (rst_n low, asynchronous): all stage valid flags clear, star radius
// returns to 32768 and every band coefficient to zero.
module limb_darkened_annulus_average (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  ldaa_pkg::in_word_t                  in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output ldaa_pkg::out_word_t                 out_data,
    input  logic                                cfg_wr_en,
    input  logic [ldaa_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  logic [15:0]                         cfg_wdata
);

    localparam int GL  = ldaa_pkg::G_LAT;
    localparam int TOT = ldaa_pkg::TOTAL_LAT;
    localparam int QB  = ldaa_pkg::Q_BITS;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [15:0]        star_radius_reg;
    logic signed [15:0] lin_coef_reg  [0:2];
    logic signed [15:0] quad_coef_reg [0:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            star_radius_reg <= ldaa_pkg::STAR_RADIUS_RESET;
            for (int n = 0; n < 3; n++)
            begin
                lin_coef_reg[n]  <= '0;
                quad_coef_reg[n] <= '0;
            end
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                ldaa_pkg::CFG_STAR_RADIUS: star_radius_reg  <= cfg_wdata;
                ldaa_pkg::CFG_LIN_BAND0:   lin_coef_reg[0]  <= cfg_wdata;
                ldaa_pkg::CFG_QUAD_BAND0:  quad_coef_reg[0] <= cfg_wdata;
                ldaa_pkg::CFG_LIN_BAND1:   lin_coef_reg[1]  <= cfg_wdata;
                ldaa_pkg::CFG_QUAD_BAND1:  quad_coef_reg[1] <= cfg_wdata;
                ldaa_pkg::CFG_LIN_BAND2:   lin_coef_reg[2]  <= cfg_wdata;
                ldaa_pkg::CFG_QUAD_BAND2:  quad_coef_reg[2] <= cfg_wdata;
                default:                   ;  // drop writes to unknown indexes
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Pipeline control: one valid flag per stage, all stages advance
    // together whenever the output register is empty or being taken.
    // ---------------------------------------------------------------
    logic [TOT-1:0] vld_reg;
    logic           adv;

    assign adv       = !vld_reg[TOT-1] || out_ready;
    assign in_ready  = adv;
    assign out_valid = vld_reg[TOT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[TOT-2:0], in_valid};
    end

    // ---------------------------------------------------------------
    // Stage 0: classify the word, order the radii, pick the band pair
    // ---------------------------------------------------------------
    ldaa_pkg::status_t  st0;
    logic [15:0]        lo0;
    logic [15:0]        hi0;
    logic signed [15:0] coef_a;
    logic signed [15:0] coef_b;
    logic signed [17:0] a18;
    logic signed [17:0] b18;
    ldaa_pkg::side_t    side0;

    always_comb
    begin
        case (in_data.band)
            2'd0:
            begin
                coef_a = lin_coef_reg[0];
                coef_b = quad_coef_reg[0];
            end
            2'd1:
            begin
                coef_a = lin_coef_reg[1];
                coef_b = quad_coef_reg[1];
            end
            2'd2:
            begin
                coef_a = lin_coef_reg[2];
                coef_b = quad_coef_reg[2];
            end
            default:
            begin
                coef_a = '0;
                coef_b = '0;
            end
        endcase
    end

    always_comb
    begin
        // band check first, then range, then equal radii
        if (in_data.band == 2'd3)
            st0 = ldaa_pkg::ST_BAD_BAND;
        else if (in_data.inner_radius > star_radius_reg
                 || in_data.outer_radius > star_radius_reg)
            st0 = ldaa_pkg::ST_BEYOND;
        else if (in_data.inner_radius == in_data.outer_radius)
            st0 = ldaa_pkg::ST_EQUAL;
        else
            st0 = ldaa_pkg::ST_OK;
    end

    // reversed radii give the same mean: swap them
    assign lo0 = (in_data.inner_radius > in_data.outer_radius)
                 ? in_data.outer_radius : in_data.inner_radius;
    assign hi0 = (in_data.inner_radius > in_data.outer_radius)
                 ? in_data.inner_radius : in_data.outer_radius;

    assign a18          = 18'(coef_a);
    assign b18          = 18'(coef_b);
    assign side0.status = st0;
    assign side0.c1     = 18'sd16384 - a18 - (b18 <<< 1);
    assign side0.c2     = a18 + (b18 <<< 1);
    assign side0.b      = coef_b;

    logic [15:0]     lo_reg;
    logic [15:0]     hi_reg;
    ldaa_pkg::side_t s0_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lo_reg <= lo0;
            hi_reg <= hi0;
            s0_reg <= side0;
        end
    end

    // ---------------------------------------------------------------
    // Per-radius terms, both edges of the annulus in parallel
    // ---------------------------------------------------------------
    logic [30:0]        ri_q;
    logic [30:0]        ro_q;
    logic signed [33:0] g_lo;
    logic signed [33:0] g_hi;
    logic [30:0]        c_lo;
    logic [30:0]        c_hi;

    ldaa_gterm u_term_lo (
        .clk         (clk),
        .en          (adv),
        .radius      (lo_reg),
        .star_radius (star_radius_reg),
        .r_norm      (ri_q),
        .g_val       (g_lo),
        .cube        (c_lo)
    );

    ldaa_gterm u_term_hi (
        .clk         (clk),
        .en          (adv),
        .radius      (hi_reg),
        .star_radius (star_radius_reg),
        .r_norm      (ro_q),
        .g_val       (g_hi),
        .cube        (c_hi)
    );

    // carry status and coefficients alongside the term pipeline
    ldaa_pkg::side_t sd_reg [0:GL-1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sd_reg[0] <= s0_reg;
            for (int n = 1; n < GL; n++)
                sd_reg[n] <= sd_reg[n-1];
        end
    end

    // ---------------------------------------------------------------
    // M1: differences and products with the coefficients
    // ---------------------------------------------------------------
    ldaa_pkg::side_t    sd_end;
    logic [30:0]        dru;
    logic signed [31:0] dr;
    logic signed [34:0] dg;
    logic signed [31:0] dc;
    logic signed [17:0] k1;
    logic signed [17:0] k2;
    logic signed [15:0] kb;

    assign sd_end = sd_reg[GL-1];
    assign k1     = sd_end.c1;
    assign k2     = sd_end.c2;
    assign kb     = sd_end.b;
    assign dru    = ro_q - ri_q;
    assign dr     = $signed({1'b0, ro_q}) - $signed({1'b0, ri_q});
    assign dg     = 35'(g_hi) - 35'(g_lo);
    assign dc     = $signed({1'b0, c_hi}) - $signed({1'b0, c_lo});

    logic signed [49:0] m1_p1_reg;
    logic signed [52:0] m1_p2_reg;
    logic signed [47:0] m1_p3_reg;
    logic [32:0]        m1_den_reg;
    logic [31:0]        m1_half_reg;
    ldaa_pkg::status_t  m1_st_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m1_p1_reg   <= k1 * dr;
            m1_p2_reg   <= k2 * dg;
            m1_p3_reg   <= kb * dc;
            m1_den_reg  <= ({2'b0, dru} << 2) + ({2'b0, dru} << 1);
            m1_half_reg <= {1'b0, dru} + {dru, 1'b0};
            m1_st_reg   <= sd_end.status;
        end
    end

    // M2: scale by 6, 3 and 2
    logic signed [55:0] n1;
    logic signed [55:0] n2;
    logic signed [55:0] n3;
    logic signed [55:0] m2_a_reg;
    logic signed [55:0] m2_b_reg;
    logic signed [55:0] m2_c_reg;
    logic [32:0]        m2_den_reg;
    logic [31:0]        m2_half_reg;
    ldaa_pkg::status_t  m2_st_reg;

    assign n1 = 56'(m1_p1_reg);
    assign n2 = 56'(m1_p2_reg);
    assign n3 = 56'(m1_p3_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m2_a_reg    <= (n1 <<< 2) + (n1 <<< 1);
            m2_b_reg    <= (n2 <<< 1) + n2;
            m2_c_reg    <= n3 <<< 1;
            m2_den_reg  <= m1_den_reg;
            m2_half_reg <= m1_half_reg;
            m2_st_reg   <= m1_st_reg;
        end
    end

    // M3: numerator
    logic signed [55:0] m3_num_reg;
    logic [32:0]        m3_den_reg;
    logic [31:0]        m3_half_reg;
    ldaa_pkg::status_t  m3_st_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m3_num_reg  <= m2_a_reg + m2_b_reg + m2_c_reg;
            m3_den_reg  <= m2_den_reg;
            m3_half_reg <= m2_half_reg;
            m3_st_reg   <= m2_st_reg;
        end
    end

    // M4: sign and magnitude
    logic              m4_neg_reg;
    logic [55:0]       m4_mag_reg;
    logic [32:0]       m4_den_reg;
    logic [31:0]       m4_half_reg;
    ldaa_pkg::status_t m4_st_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m4_neg_reg  <= m3_num_reg[55];
            m4_mag_reg  <= m3_num_reg[55] ? 56'(-m3_num_reg) : 56'(m3_num_reg);
            m4_den_reg  <= m3_den_reg;
            m4_half_reg <= m3_half_reg;
            m4_st_reg   <= m3_st_reg;
        end
    end

    // M5: add half the divisor for round-half-away
    logic [55:0]       m5_divd_reg;
    logic              m5_neg_reg;
    logic [32:0]       m5_den_reg;
    ldaa_pkg::status_t m5_st_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m5_divd_reg <= m4_mag_reg + 56'(m4_half_reg);
            m5_neg_reg  <= m4_neg_reg;
            m5_den_reg  <= m4_den_reg;
            m5_st_reg   <= m4_st_reg;
        end
    end

    // M6: flag quotients too large for the quotient stages
    logic [49:0]       m6_rem_reg;
    logic              m6_ovf_reg;
    logic              m6_neg_reg;
    logic [32:0]       m6_den_reg;
    ldaa_pkg::status_t m6_st_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m6_rem_reg <= m5_divd_reg[49:0];
            m6_ovf_reg <= m5_divd_reg >= (56'(m5_den_reg) << QB);
            m6_neg_reg <= m5_neg_reg;
            m6_den_reg <= m5_den_reg;
            m6_st_reg  <= m5_st_reg;
        end
    end

    // ---------------------------------------------------------------
    // Quotient stages, one bit each, most significant first
    // ---------------------------------------------------------------
    logic [49:0]       qrem_reg [0:QB-1];
    logic [QB-1:0]     qq_reg   [0:QB-1];
    logic [32:0]       qden_reg [0:QB-1];
    logic              qneg_reg [0:QB-1];
    logic              qovf_reg [0:QB-1];
    ldaa_pkg::status_t qst_reg  [0:QB-1];

    genvar m;
    for (m = 0; m < QB; m++)
    begin : g_quot
        logic [49:0]       prem;
        logic [QB-1:0]     pq;
        logic [32:0]       pden;
        logic              pneg;
        logic              povf;
        ldaa_pkg::status_t pst;
        logic [49:0]       sh;
        logic              take;
        if (m == 0)
        begin : g_first
            assign prem = m6_rem_reg;
            assign pq   = '0;
            assign pden = m6_den_reg;
            assign pneg = m6_neg_reg;
            assign povf = m6_ovf_reg;
            assign pst  = m6_st_reg;
        end
        else
        begin : g_rest
            assign prem = qrem_reg[m-1];
            assign pq   = qq_reg[m-1];
            assign pden = qden_reg[m-1];
            assign pneg = qneg_reg[m-1];
            assign povf = qovf_reg[m-1];
            assign pst  = qst_reg[m-1];
        end
        assign sh   = 50'(pden) << (QB - 1 - m);
        assign take = prem >= sh;
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                qrem_reg[m] <= take ? prem - sh : prem;
                qq_reg[m]   <= pq | (take ? (QB'(1) << (QB - 1 - m)) : '0);
                qden_reg[m] <= pden;
                qneg_reg[m] <= pneg;
                qovf_reg[m] <= povf;
                qst_reg[m]  <= pst;
            end
        end
    end

    // ---------------------------------------------------------------
    // Output register: sign, saturate, zero on any error status
    // ---------------------------------------------------------------
    logic [QB-1:0]       qf;
    logic                qneg_f;
    logic                qovf_f;
    ldaa_pkg::status_t   qst_f;
    logic signed [15:0]  mean_next;
    ldaa_pkg::out_word_t out_reg;

    assign qf     = qq_reg[QB-1];
    assign qneg_f = qneg_reg[QB-1];
    assign qovf_f = qovf_reg[QB-1];
    assign qst_f  = qst_reg[QB-1];

    always_comb
    begin
        if (qst_f != ldaa_pkg::ST_OK)
            mean_next = '0;
        else if (!qneg_f)
            mean_next = (qovf_f || qf > QB'(32767)) ? 16'sh7FFF : $signed(qf[15:0]);
        else
            mean_next = (qovf_f || qf > QB'(32768)) ? 16'sh8000 : $signed(16'(~qf + 1'b1));
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg.mean_intensity <= mean_next;
            out_reg.status         <= qst_f;
        end
    end

    assign out_data = out_reg;

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    // an error word never carries an intensity
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != ldaa_pkg::ST_OK |-> out_data.mean_intensity == 16'sd0)
        else $error("nonzero intensity on an error word");

    // ordered distinct radii stay strictly ordered after normalising
    assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[GL] && sd_end.status == ldaa_pkg::ST_OK |-> ro_q > ri_q)
        else $error("normalised radii not ordered");

    // a good word never reaches the divider with a zero divisor
    assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[GL+1] && m1_st_reg == ldaa_pkg::ST_OK |-> m1_den_reg != '0)
        else $error("zero divisor for a good word");

    // a held result stays put while the pipeline is stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data) && $stable(vld_reg))
        else $error("pipeline moved during a stall");

    // nothing is valid once reset has been seen
    assert property (@(posedge clk) !rst_n |=> !out_valid)
        else $error("result valid during reset");

endmodule
